[rtl/utf8_cyrillic_to_cp1251_unit_assert.svh]
// assertion macros shared by the checker
`ifndef UTF8_CYRILLIC_TO_CP1251_UNIT_ASSERT_SVH
`define UTF8_CYRILLIC_TO_CP1251_UNIT_ASSERT_SVH

// clocked check, off while reset is held
`define UTF8CP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("utf8cp check failed");

// clocked check that also runs during reset
`define UTF8CP_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("utf8cp check failed");

`endif

[rtl/utf8cp_pkg.sv]
package utf8cp_pkg;

    localparam logic [7:0] LEAD_BYTE_D0 = 8'hD0;
    localparam logic [7:0] LEAD_BYTE_D1 = 8'hD1;
    localparam logic [7:0] LEAD_BYTE_D2 = 8'hD2;
    localparam logic [7:0] D0_OFFSET    = 8'd48;

    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_D0   = 2'd1,
        LEAD_D1   = 2'd2,
        LEAD_D2   = 2'd3
    } t_lead;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } t_result;

    // continuation byte after a pending lead
    function automatic t_result map_cont(input t_lead lead, input logic [7:0] b);
        t_result res;
        res.valid = 1'b0;
        res.code  = 8'd0;
        unique case (lead)
            LEAD_D0: begin
                res.valid = 1'b1;
                unique case (b)
                    8'h84:   res.code = 8'd170;
                    8'h86:   res.code = 8'd178;
                    8'h87:   res.code = 8'd175;
                    default: res.code = b + D0_OFFSET;
                endcase
            end
            LEAD_D1: begin
                res.valid = 1'b1;
                unique case (b)
                    8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
                    8'h85, 8'h86, 8'h87, 8'h88, 8'h89: res.code = b + 8'd112;
                    8'h8C:   res.code = 8'd252;
                    8'h8E:   res.code = 8'd254;
                    8'h8F:   res.code = 8'd255;
                    8'h94:   res.code = 8'd186;
                    8'h96:   res.code = 8'd179;
                    8'h97:   res.code = 8'd191;
                    default: res.valid = 1'b0;
                endcase
            end
            LEAD_D2: begin
                res.valid = 1'b1;
                unique case (b)
                    8'h90:   res.code = 8'd165;
                    8'h91:   res.code = 8'd180;
                    default: res.valid = 1'b0;
                endcase
            end
            default: res.valid = 1'b0;
        endcase
        if (!res.valid) begin
            res.code = 8'd0;
        end
        return res;
    endfunction

endpackage

[rtl/utf8_cyrillic_to_cp1251_unit.sv]
// UTF-8 to Windows-1251 transcoder for Cyrillic and Ukrainian letters. Takes one UTF-8
// byte per beat and gives exactly one result beat per input beat, in order: a code byte,
// a flag saying whether a character came out, and a copy of the final flag. Lead bytes
// 0xD0, 0xD1 and 0xD2 are held in a two-bit register and give no character; the byte
// after them is mapped as their continuation, and all other bytes pass through. A lead
// on the final byte acts as if followed by a zero byte. The unit takes one byte per clock
// while o_stall is low; each result is registered in r_out, or first parked in r_skid
// when the output is held. The two-entry output buffer keeps o_stall registered, so input
// is taken while a result waits to be taken.
module utf8_cyrillic_to_cp1251_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_code,
    output logic       o_out_valid,
    output logic       o_out_final
);
    import utf8cp_pkg::*;

    typedef struct packed {
        t_result res;
        logic    fin;
    } t_beat;

    t_lead   r_lead;
    t_lead   n_lead;
    t_beat   n_beat;
    t_beat   r_out;
    t_beat   r_skid;
    logic    r_out_v;
    logic    r_skid_v;
    logic    in_acc;
    logic    out_acc;
    t_lead   byte_lead;

    assign o_stall = r_skid_v;
    assign in_acc  = i_valid && !r_skid_v;
    assign out_acc = r_out_v && !i_stall;

    always_comb begin
        unique case (i_in_byte)
            LEAD_BYTE_D0: byte_lead = LEAD_D0;
            LEAD_BYTE_D1: byte_lead = LEAD_D1;
            LEAD_BYTE_D2: byte_lead = LEAD_D2;
            default:      byte_lead = LEAD_NONE;
        endcase
    end

    always_comb begin
        n_lead           = LEAD_NONE;
        n_beat.fin       = i_is_final;
        n_beat.res.valid = 1'b1;
        n_beat.res.code  = i_in_byte;
        if (r_lead != LEAD_NONE) begin
            n_beat.res = map_cont(r_lead, i_in_byte);
        end else if (byte_lead != LEAD_NONE) begin
            if (i_is_final) begin
                // lead with nothing after it: treat as followed by zero
                n_beat.res = map_cont(byte_lead, 8'd0);
            end else begin
                n_lead           = byte_lead;
                n_beat.res.valid = 1'b0;
                n_beat.res.code  = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= LEAD_NONE;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (in_acc) begin
                r_lead <= n_lead;
            end
            if (r_skid_v) begin
                if (out_acc) begin
                    r_out    <= r_skid;
                    r_skid_v <= 1'b0;
                end
            end else if (in_acc) begin
                if (!r_out_v || out_acc) begin
                    r_out   <= n_beat;
                    r_out_v <= 1'b1;
                end else begin
                    // output held, park the new beat
                    r_skid   <= n_beat;
                    r_skid_v <= 1'b1;
                end
            end else if (out_acc) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_v;
    assign o_out_code  = r_out.res.code;
    assign o_out_valid = r_out.res.valid;
    assign o_out_final = r_out.fin;

endmodule

[rtl/utf8cp_checker.sv]
`include "utf8_cyrillic_to_cp1251_unit_assert.svh"

module utf8cp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_in_byte,
    input logic       i_is_final,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_code,
    input logic       o_out_valid,
    input logic       o_out_final
);
    import utf8cp_pkg::*;

    logic in_lead;
    logic empty_beat;
    logic final_lead_in;

    assign in_lead = (i_in_byte == LEAD_BYTE_D0) || (i_in_byte == LEAD_BYTE_D1) ||
                     (i_in_byte == LEAD_BYTE_D2);

    assign empty_beat    = o_valid && !o_out_valid;
    assign final_lead_in = !o_valid && i_valid && !o_stall && i_is_final && in_lead;

    `UTF8CP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

    // the second buffer entry only fills behind a held result
    `UTF8CP_ASSERT(a_stall_has_out, i_clk, i_rst_n, o_stall |-> o_valid)

    `UTF8CP_ASSERT(a_no_char_zero, i_clk, i_rst_n, empty_beat |-> (o_out_code == 8'd0))

    // a final lead byte taken on an empty unit comes out next cycle as a final beat
    `UTF8CP_ASSERT(a_final_lead, i_clk, i_rst_n, final_lead_in |=> (o_valid && o_out_final))

endmodule

bind utf8_cyrillic_to_cp1251_unit utf8cp_checker u_utf8cp_checker (.*);

[bench/tb_utf8_cyrillic_to_cp1251_unit.sv]
module tb_utf8_cyrillic_to_cp1251_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8cp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [7:0] code;
        logic       has_char;
        logic       is_last;
    } t_cp_beat;

    class cp1251_scoreboard;
        t_lead    lead_q;
        t_cp_beat expected_chars[$];
        int       errors;
        int       bytes_in;
        int       beats_out;
        int       chars_out;
        int       empty_out;
        int       last_out;

        function new();
            lead_q = LEAD_NONE;
        endfunction

        function void decode_trail(input t_lead lead, input logic [7:0] b,
                                   output logic [7:0] code, output logic ok);
            code = 8'd0;
            ok   = 1'b0;
            case (lead)
                LEAD_D0: begin
                    ok = 1'b1;
                    case (b)
                        8'h84:   code = 8'd170;
                        8'h86:   code = 8'd178;
                        8'h87:   code = 8'd175;
                        default: code = b + D0_OFFSET;
                    endcase
                end
                LEAD_D1: begin
                    ok = 1'b1;
                    if (b >= 8'h80 && b <= 8'h89) begin
                        code = b + 8'd112;
                    end else begin
                        case (b)
                            8'h8C:   code = 8'd252;
                            8'h8E:   code = 8'd254;
                            8'h8F:   code = 8'd255;
                            8'h94:   code = 8'd186;
                            8'h96:   code = 8'd179;
                            8'h97:   code = 8'd191;
                            default: ok = 1'b0;
                        endcase
                    end
                end
                LEAD_D2: begin
                    ok = 1'b1;
                    case (b)
                        8'h90:   code = 8'd165;
                        8'h91:   code = 8'd180;
                        default: ok = 1'b0;
                    endcase
                end
                default: ok = 1'b0;
            endcase
            if (!ok) begin
                code = 8'd0;
            end
        endfunction

        function void note_byte(input logic [7:0] b, input logic last);
            t_cp_beat exp_beat;
            t_lead    seen;
            logic [7:0] code;
            logic ok;
            code = b;
            ok   = 1'b1;
            case (b)
                LEAD_BYTE_D0: seen = LEAD_D0;
                LEAD_BYTE_D1: seen = LEAD_D1;
                LEAD_BYTE_D2: seen = LEAD_D2;
                default:      seen = LEAD_NONE;
            endcase
            if (lead_q != LEAD_NONE) begin
                decode_trail(lead_q, b, code, ok);
                lead_q = LEAD_NONE;
            end else if (seen != LEAD_NONE) begin
                // a lead on the last byte behaves as if a zero byte followed
                if (last) begin
                    decode_trail(seen, 8'd0, code, ok);
                end else begin
                    ok     = 1'b0;
                    lead_q = seen;
                end
            end
            if (last) begin
                lead_q = LEAD_NONE;
            end
            exp_beat.code     = ok ? code : 8'd0;
            exp_beat.has_char = ok;
            exp_beat.is_last  = last;
            expected_chars = {expected_chars, exp_beat};
            bytes_in++;
        endfunction

        function void check_char(input logic [7:0] code, input logic has_char,
                                 input logic is_last);
            t_cp_beat exp_beat;
            beats_out++;
            if (expected_chars.size() == 0) begin
                $error("result beat with nothing expected: code %0d", code);
                errors++;
                return;
            end
            exp_beat = expected_chars.pop_front();
            if (code !== exp_beat.code) begin
                $error("out_code: expected %0d, got %0d", exp_beat.code, code);
                errors++;
            end
            if (has_char !== exp_beat.has_char) begin
                $error("out_valid: expected %0b, got %0b", exp_beat.has_char, has_char);
                errors++;
            end
            if (is_last !== exp_beat.is_last) begin
                $error("out_final: expected %0b, got %0b", exp_beat.is_last, is_last);
                errors++;
            end
            if (exp_beat.has_char) chars_out++;
            else empty_out++;
            if (exp_beat.is_last) last_out++;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_is_final;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_code;
    logic       o_out_valid;
    logic       o_out_final;

    cp1251_scoreboard sb;
    int  cycles;
    bit  src_idle_en;
    bit  sink_idle_en;
    int  hold_left;
    int  stall_left;

    utf8_cyrillic_to_cp1251_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .i_is_final (i_is_final),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_code (o_out_code),
        .o_out_valid(o_out_valid),
        .o_out_final(o_out_final)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
    end

    // both sides of the handshake are sampled here, input beat noted first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_byte(i_in_byte, i_is_final);
            end
            if (o_valid && !i_stall) begin
                sb.check_char(o_out_code, o_out_valid, o_out_final);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycles, sb.pending());
            $display("** utf8_cyrillic_to_cp1251_unit: FAILED **");
            $finish;
        end
    end

    // receiver: random stall bursts plus a long hold counted here
    initial begin
        i_stall    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                i_stall    = 1'b1;
                stall_left = $urandom_range(1, 7) - 1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [7:0] b, input logic last);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_in_byte  = b;
        i_is_final = last;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_trail(input logic [7:0] lead);
        logic [7:0] t;
        t = 8'($urandom_range(8'h80, 8'hBF));
        if (lead == LEAD_BYTE_D2 && $urandom_range(0, 1) == 0) begin
            t = {7'b1001000, 1'($urandom_range(0, 1))};
        end else if (lead == LEAD_BYTE_D1 && $urandom_range(0, 1) == 0) begin
            t = 8'($urandom_range(8'h80, 8'h97));
        end else if ($urandom_range(0, 9) == 0) begin
            t = 8'($urandom);
        end
        return t;
    endfunction

    task automatic random_text(input int n);
        int sent;
        int kind;
        logic [7:0] lead;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 99);
            lead = 8'(LEAD_BYTE_D0 + $urandom_range(0, 2));
            if (kind < 45) begin
                send_beat(lead, $urandom_range(0, 49) == 0);
                send_beat(pick_trail(lead), $urandom_range(0, 14) == 0);
                sent += 2;
            end else if (kind < 65) begin
                send_beat(8'($urandom_range(0, 127)), $urandom_range(0, 19) == 0);
                sent++;
            end else if (kind < 82) begin
                send_beat(8'($urandom), $urandom_range(0, 19) == 0);
                sent++;
            end else if (kind < 92) begin
                // broken pair: lead followed by another lead or plain text
                send_beat(lead, 1'b0);
                if ($urandom_range(0, 1) == 0) begin
                    send_beat(8'(LEAD_BYTE_D0 + $urandom_range(0, 2)), $urandom_range(0, 3) == 0);
                end else begin
                    send_beat(8'($urandom_range(0, 127)), $urandom_range(0, 3) == 0);
                end
                sent += 2;
            end else begin
                send_beat(lead, 1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        cycles       = 0;
        hold_left    = 0;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_in_byte    = 8'd0;
        i_is_final   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: plain bytes, every mapped letter class, dead trails, leads on last byte
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(LEAD_BYTE_D0, 1'b0); send_beat(8'h84, 1'b0);
        send_beat(LEAD_BYTE_D0, 1'b0); send_beat(8'h86, 1'b0);
        send_beat(LEAD_BYTE_D0, 1'b0); send_beat(8'h87, 1'b0);
        send_beat(LEAD_BYTE_D0, 1'b0); send_beat(8'hFF, 1'b0);
        send_beat(LEAD_BYTE_D1, 1'b0); send_beat(8'h80, 1'b0);
        send_beat(LEAD_BYTE_D1, 1'b0); send_beat(8'h8C, 1'b0);
        send_beat(LEAD_BYTE_D1, 1'b0); send_beat(8'h97, 1'b0);
        send_beat(LEAD_BYTE_D1, 1'b0); send_beat(8'h8A, 1'b0);
        send_beat(LEAD_BYTE_D2, 1'b0); send_beat(8'h90, 1'b0);
        send_beat(LEAD_BYTE_D2, 1'b0); send_beat(8'h91, 1'b0);
        send_beat(LEAD_BYTE_D2, 1'b0); send_beat(8'h41, 1'b0);
        send_beat(LEAD_BYTE_D0, 1'b1);
        send_beat(LEAD_BYTE_D1, 1'b1);
        send_beat(LEAD_BYTE_D2, 1'b1);
        send_beat(LEAD_BYTE_D0, 1'b0); send_beat(LEAD_BYTE_D1, 1'b1);
        wait_drained();

        random_text(520);

        // long receiver hold while the sender keeps pushing
        src_idle_en = 1'b0;
        @(posedge i_clk);
        hold_left = 80;
        @(negedge i_clk);
        random_text(40);
        src_idle_en = 1'b1;
        wait_drained();

        sink_idle_en = 1'b0;
        random_text(250);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b1;
        random_text(250);

        // closing stretch at full rate on both sides
        sink_idle_en = 1'b0;
        random_text(260);
        wait_drained();
        repeat (6) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected beats never arrived", sb.pending());
            sb.errors++;
        end

        $display("sent %0d bytes, checked %0d result beats in %0d cycles",
                 sb.bytes_in, sb.beats_out, cycles);
        $display("%0d characters out, %0d empty beats, %0d last-byte beats",
                 sb.chars_out, sb.empty_out, sb.last_out);
        if (sb.errors == 0) begin
            $display("** utf8_cyrillic_to_cp1251_unit: PASSED **");
        end else begin
            $display("** utf8_cyrillic_to_cp1251_unit: FAILED **");
        end
        $finish;
    end

endmodule
